// ===== rtl/core/can_bus_arbiter_with_rx_queues_unit_assert.svh =====
// assertion macros shared by the can bus arbiter modules
`ifndef CAN_BUS_ARBITER_WITH_RX_QUEUES_UNIT_ASSERT_SVH
`define CAN_BUS_ARBITER_WITH_RX_QUEUES_UNIT_ASSERT_SVH
// property checked on every clock edge outside reset
`define CBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication checked on every clock edge outside reset
`define CBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/cba_pkg.sv =====
// shared types and constants of the can bus arbiter
`timescale 1ns / 1ps
package cba_pkg;
  localparam int NodeSlots    = 4;
  localparam int PendDepth    = 16;
  localparam int RxDepth      = 8;
  localparam int SlotW        = $clog2(NodeSlots);
  localparam int PendIdxW     = $clog2(PendDepth);
  localparam int PendCntW     = $clog2(PendDepth + 1);
  localparam int RxIdxW       = $clog2(RxDepth);
  localparam int RxCntW       = $clog2(RxDepth + 1);
  localparam int IdentW       = 29;

  localparam logic [1:0] FuncSubmit  = 2'd0;
  localparam logic [1:0] FuncArb     = 2'd1;
  localparam logic [1:0] FuncReceive = 2'd2;

  localparam logic [2:0] CfgMask = 3'd4;

  typedef struct packed {
    logic [IdentW-1:0] ident;
    logic [3:0]        len;
    logic [63:0]       payload;
    logic [7:0]        sender;
  } frame_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch request
    logic pend_rd;     // read pending entry at scan index
    logic scan_cmp;    // compare read entry with best
    logic shift;       // shift pending entry down
    logic pend_wr;     // append request frame
    logic pend_dec;
    logic rx_wr;       // write best frame into slot fifo
    logic rx_rd;       // read head of slot fifo
    logic rx_pop;
    logic [SlotW-1:0] slot;
    logic [PendIdxW-1:0] idx;
    logic set_ok;
    logic clr_ok;
    logic show_rx;     // show rx read data on result
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [PendCntW-1:0] pend_count;
    logic [PendIdxW-1:0] best_idx;
    logic [NodeSlots-1:0] active;
    logic [NodeSlots-1:0] is_sender;
    logic [NodeSlots-1:0] rx_full;
    logic [NodeSlots-1:0] rx_empty;
    logic                 hit;
    logic [SlotW-1:0]     hit_slot;
    logic                 len_ok;
    logic [1:0]           func;
  } sts_t;
endpackage

// ===== rtl/core/cba_ctrl.sv =====
// sequencer for submit, arbitration scan, shift, delivery and receive
`timescale 1ns / 1ps
module cba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  cba_pkg::sts_t   sts_i,
  output cba_pkg::cmd_t   cmd_o
);
  import cba_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDecode, StScan, StShift, StDeliver, StRxRead, StDone
  } state_e;

  state_e               state_q;
  logic [PendIdxW:0]    cnt_q;
  logic [SlotW:0]       slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      slot_q  <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) state_q <= StDecode;
        end
        StDecode: begin
          cnt_q  <= (PendIdxW+1)'(1);
          slot_q <= '0;
          case (sts_i.func)
            FuncArb: state_q <= (sts_i.pend_count != '0) ? StScan : StDone;
            FuncReceive: state_q <= (sts_i.hit && !sts_i.rx_empty[sts_i.hit_slot]) ?
                                    StRxRead : StDone;
            default: state_q <= StDone;
          endcase
        end
        StScan: begin
          // one entry compared a cycle, each on data read in the cycle before; a
          // closing step past the last compare lets it land before the winner is taken
          if ({1'b0, cnt_q} > (PendCntW+1)'(sts_i.pend_count)) begin
            state_q <= StShift;
            cnt_q   <= {1'b0, sts_i.best_idx};
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StShift: begin
          if ({1'b0, cnt_q} + 1'b1 >= (PendCntW+1)'(sts_i.pend_count)) begin
            state_q <= StDeliver;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StDeliver: begin
          if (slot_q == (SlotW+1)'(NodeSlots)) begin
            state_q <= StDone;
          end else if (sts_i.active[slot_q[SlotW-1:0]] &&
                       !sts_i.is_sender[slot_q[SlotW-1:0]] &&
                       sts_i.rx_full[slot_q[SlotW-1:0]]) begin
            state_q <= StDone;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        StRxRead: state_q <= StDone;
        StDone:   state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end

  logic [SlotW-1:0] cur_slot;
  logic             deliver_here;
  assign cur_slot     = slot_q[SlotW-1:0];
  assign deliver_here = (state_q == StDeliver) && (slot_q != (SlotW+1)'(NodeSlots)) &&
                        sts_i.active[cur_slot] && !sts_i.is_sender[cur_slot];

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == StIdle) && start_i;
    cmd_o.slot     = cur_slot;
    cmd_o.idx      = cnt_q[PendIdxW-1:0];
    cmd_o.done     = (state_q == StDone);
    case (state_q)
      StDecode: begin
        cmd_o.clr_ok = 1'b1;
        if (sts_i.func == FuncSubmit && sts_i.len_ok && sts_i.hit &&
            sts_i.pend_count < PendCntW'(PendDepth)) begin
          cmd_o.pend_wr = 1'b1;
          cmd_o.set_ok  = 1'b1;
        end
        cmd_o.pend_rd = 1'b1;
        cmd_o.idx     = '0;
      end
      StScan: begin
        if ({1'b0, cnt_q} <= (PendCntW+1)'(sts_i.pend_count)) begin
          cmd_o.scan_cmp = 1'b1;
          cmd_o.pend_rd  = 1'b1;
        end
      end
      StShift: begin
        if ({1'b0, cnt_q} + 1'b1 < (PendCntW+1)'(sts_i.pend_count)) cmd_o.shift = 1'b1;
        else begin
          cmd_o.pend_dec = 1'b1;
          cmd_o.set_ok   = 1'b1;
        end
      end
      StDeliver: begin
        if (deliver_here) begin
          if (sts_i.rx_full[cur_slot]) cmd_o.clr_ok = 1'b1;
          else cmd_o.rx_wr = 1'b1;
        end
      end
      StRxRead: begin
        cmd_o.rx_pop    = 1'b1;
        cmd_o.set_ok    = 1'b1;
        cmd_o.show_rx   = 1'b1;
        cmd_o.slot      = sts_i.hit_slot;
      end
      default: ;
    endcase
    if (state_q == StDecode) cmd_o.rx_rd = 1'b1;
    if (state_q == StDecode) cmd_o.slot  = sts_i.hit_slot;
  end

  assign busy_o = (state_q != StIdle);

  `include "can_bus_arbiter_with_rx_queues_unit_assert.svh"
  `CBA_ASSERT_IMP(a_done_from_busy, cmd_o.done, $past(busy_o), "done without work")
  `CBA_ASSERT(a_no_wr_and_pop, !(cmd_o.rx_wr && cmd_o.rx_pop), "fifo write and pop")
  `CBA_ASSERT(a_load_idle, cmd_o.load |=> busy_o, "load did not start work")
endmodule

// ===== rtl/core/cba_dp.sv =====
// pending list, receive fifos, slot registers and result registers
`timescale 1ns / 1ps
module cba_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_index_i,
  input  logic [7:0]                 cfg_data_i,
  input  logic [1:0]                 func_i,
  input  logic [7:0]                 node_addr_i,
  input  logic [cba_pkg::IdentW-1:0] frame_ident_i,
  input  logic [3:0]                 frame_len_i,
  input  logic [63:0]                frame_payload_i,
  input  cba_pkg::cmd_t              cmd_i,
  output cba_pkg::sts_t              sts_o,
  output logic                       ok_o,
  output logic [cba_pkg::IdentW-1:0] out_ident_o,
  output logic [3:0]                 out_len_o,
  output logic [63:0]                out_payload_o,
  output logic [7:0]                 out_sender_o,
  output logic [4:0]                 pending_count_o
);
  import cba_pkg::*;

  logic [7:0]           slot_node_q [NodeSlots];
  logic [NodeSlots-1:0] mask_q;
  logic [PendCntW-1:0]  pcnt_q;
  logic [RxIdxW-1:0]    head_q [NodeSlots];
  logic [RxCntW-1:0]    fill_q [NodeSlots];
  logic                 ok_q;
  frame_t               req_q, best_q, prd_q, rxrd_q;
  logic [1:0]           func_q;
  logic [PendIdxW-1:0]  best_idx_q;

  frame_t pend_mem [PendDepth];
  frame_t rx_mem   [NodeSlots*RxDepth];

  logic [NodeSlots-1:0] hit_v;
  logic                 hit;
  logic [SlotW-1:0]     hit_slot;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = NodeSlots - 1; s >= 0; s--) begin
      hit_v[s] = mask_q[s] && (slot_node_q[s] == req_q.sender);
      if (hit_v[s]) begin
        hit      = 1'b1;
        hit_slot = SlotW'(s);
      end
    end
  end

  // config, ok flag, function, pending count and per-slot fifo counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      pcnt_q <= '0;
      ok_q   <= 1'b0;
      func_q <= '0;
      for (int s = 0; s < NodeSlots; s++) begin
        slot_node_q[s] <= '0;
        head_q[s]      <= '0;
        fill_q[s]      <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i < 3'(NodeSlots)) slot_node_q[cfg_index_i[SlotW-1:0]] <= cfg_data_i;
        else if (cfg_index_i == CfgMask) begin
          for (int s = 0; s < NodeSlots; s++) begin
            if (cfg_data_i[s] && !mask_q[s]) begin
              head_q[s] <= '0;
              fill_q[s] <= '0;
            end
          end
          mask_q <= cfg_data_i[NodeSlots-1:0];
        end
      end
      if (cmd_i.load) func_q <= func_i;
      if (cmd_i.set_ok) ok_q <= 1'b1;
      else if (cmd_i.clr_ok) ok_q <= 1'b0;
      if (cmd_i.pend_wr) pcnt_q <= pcnt_q + 1'b1;
      if (cmd_i.pend_dec) pcnt_q <= pcnt_q - 1'b1;
      if (cmd_i.rx_wr) fill_q[cmd_i.slot] <= fill_q[cmd_i.slot] + 1'b1;
      if (cmd_i.rx_pop) begin
        fill_q[cmd_i.slot] <= fill_q[cmd_i.slot] - 1'b1;
        head_q[cmd_i.slot] <= head_q[cmd_i.slot] + 1'b1;
      end
    end
  end

  logic [PendIdxW-1:0] rd_idx;
  logic [RxIdxW-1:0]   wr_pos;
  assign rd_idx = cmd_i.shift ? cmd_i.idx + 1'b1 : cmd_i.idx;
  assign wr_pos = head_q[cmd_i.slot] + fill_q[cmd_i.slot][RxIdxW-1:0];

  // request latch, pending list and scan, receive fifo write and read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q.ident   <= frame_ident_i;
      req_q.len     <= frame_len_i;
      req_q.payload <= frame_payload_i;
      req_q.sender  <= node_addr_i;
    end
    if (cmd_i.pend_wr) pend_mem[pcnt_q[PendIdxW-1:0]] <= req_q;
    if (cmd_i.pend_rd) prd_q <= pend_mem[rd_idx];
    if (cmd_i.shift) pend_mem[cmd_i.idx] <= pend_mem[rd_idx];
    if (cmd_i.pend_rd && !cmd_i.scan_cmp) begin
      best_idx_q <= '0;
      best_q     <= pend_mem[rd_idx];
    end
    if (cmd_i.scan_cmp && prd_q.ident < best_q.ident) begin
      best_q     <= prd_q;
      best_idx_q <= cmd_i.idx - 1'b1;
    end
    if (cmd_i.rx_wr) rx_mem[{cmd_i.slot, wr_pos}] <= best_q;
    if (cmd_i.rx_rd) rxrd_q <= rx_mem[{cmd_i.slot, head_q[cmd_i.slot]}];
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ident_o   <= '0;
      out_len_o     <= '0;
      out_payload_o <= '0;
      out_sender_o  <= '0;
    end else if (cmd_i.load) begin
      out_ident_o   <= '0;
      out_len_o     <= '0;
      out_payload_o <= '0;
      out_sender_o  <= '0;
    end else if (cmd_i.show_rx) begin
      out_ident_o   <= rxrd_q.ident;
      out_len_o     <= rxrd_q.len;
      out_payload_o <= rxrd_q.payload;
      out_sender_o  <= rxrd_q.sender;
    end
  end

  always_comb begin
    for (int s = 0; s < NodeSlots; s++) begin
      sts_o.is_sender[s] = (slot_node_q[s] == best_q.sender);
      sts_o.rx_full[s]   = (fill_q[s] >= RxCntW'(RxDepth));
      sts_o.rx_empty[s]  = (fill_q[s] == '0);
    end
    sts_o.pend_count = pcnt_q;
    sts_o.best_idx   = best_idx_q;
    sts_o.active     = mask_q;
    sts_o.hit        = hit;
    sts_o.hit_slot   = hit_slot;
    sts_o.len_ok     = (req_q.len <= 4'd8);
    sts_o.func       = func_q;
  end

  assign ok_o            = ok_q;
  assign pending_count_o = 5'(pcnt_q);

  `include "can_bus_arbiter_with_rx_queues_unit_assert.svh"
  `CBA_ASSERT(a_pcnt_range, pcnt_q <= PendCntW'(PendDepth), "pending count overflow")
  `CBA_ASSERT_IMP(a_no_pend_wr_full, cmd_i.pend_wr, pcnt_q < PendCntW'(PendDepth), "write full")
  `CBA_ASSERT_IMP(a_pop_nonempty, cmd_i.rx_pop, fill_q[cmd_i.slot] != '0, "pop empty fifo")
endmodule

// ===== rtl/core/can_bus_arbiter_with_rx_queues_unit.sv =====
// Emulated CAN bus: node slots, pending transmit list, per-slot receive fifos.
// Channels: a request is accepted when start is high and busy is low; the
// fields func_i, node_addr_i and frame_* are sampled at that edge. func 0
// submits a frame, 1 arbitrates the lowest-id pending frame and delivers it to
// every other active slot until one with a full fifo is met, 2 pops the
// addressed node's fifo. The result appears for one cycle with done_o high;
// the receiver cannot stall. A submit, an unknown func, a receive that finds
// nothing and an arbitrate on an empty list go from decode straight to done;
// a receive that returns a frame first passes through a fifo read state.
// Arbitration scans the pending list one entry a cycle plus a settling step,
// shifts the entries after the winner down one a cycle, then visits the slots
// one a cycle, stopping early at a full fifo.
// One request is in work at a time; busy stays high through the done_o cycle,
// so the next request is taken in the cycle after the result at the earliest.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered;
// the user must see that they are made only while busy is low, which the
// block does not enforce. Reset empties the pending list and all receive
// fifos and clears the slot registers; no clearing pass is needed.
`timescale 1ns / 1ps
module can_bus_arbiter_with_rx_queues_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_index_i,
  input  logic [7:0]                 cfg_data_i,
  input  logic [1:0]                 func_i,
  input  logic [7:0]                 node_addr_i,
  input  logic [cba_pkg::IdentW-1:0] frame_ident_i,
  input  logic [3:0]                 frame_len_i,
  input  logic [63:0]                frame_payload_i,
  output logic                       done_o,
  output logic                       ok_o,
  output logic [cba_pkg::IdentW-1:0] out_ident_o,
  output logic [3:0]                 out_len_o,
  output logic [63:0]                out_payload_o,
  output logic [7:0]                 out_sender_o,
  output logic [4:0]                 pending_count_o
);
  import cba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cba_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .sts_i(sts), .cmd_o(cmd)
  );

  cba_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .func_i, .node_addr_i,
    .frame_ident_i, .frame_len_i, .frame_payload_i, .cmd_i(cmd), .sts_o(sts),
    .ok_o, .out_ident_o, .out_len_o, .out_payload_o, .out_sender_o, .pending_count_o
  );

  assign done_o = cmd.done;
endmodule
